// ===== design/linear_key_value_table_macros.svh =====
// Assertion helpers used by the checker module of this block.
`ifndef LINEAR_KEY_VALUE_TABLE_MACROS_SVH
`define LINEAR_KEY_VALUE_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKV_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/lkv_pkg.sv =====
`default_nettype none

package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int CMD_W       = 2;
  localparam int KEY_W       = 16;
  localparam int VAL_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int OUT_CNT_W   = 5;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DUP    = 2'd3;

  localparam logic signed [VAL_W-1:0] UNDEF_RESET = -32'sd9999;

  // Per-cycle control handed from the sequencer to every cell.
  typedef struct packed {
    logic load_new;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/lkv_req_if.sv =====
`default_nettype none

interface lkv_req_if;
  logic                                    valid;
  logic                                    ready;
  logic        [lkv_pkg::CMD_W-1:0]        cmd;
  logic        [lkv_pkg::KEY_W-1:0]        key;
  logic signed [lkv_pkg::VAL_W-1:0]        entry_value;

  modport source (output valid, output cmd, output key, output entry_value, input ready);
  modport sink   (input valid, input cmd, input key, input entry_value, output ready);
endinterface

`default_nettype wire

// ===== design/lkv_rsp_if.sv =====
`default_nettype none

interface lkv_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic        [lkv_pkg::STATUS_W-1:0]  status;
  logic signed [lkv_pkg::VAL_W-1:0]     read_value;
  logic        [lkv_pkg::OUT_CNT_W-1:0] entry_count;
  logic                                 is_empty;
  logic                                 is_full;

  modport source (output valid, output status, output read_value, output entry_count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// ===== design/lkv_cfg_if.sv =====
`default_nettype none

interface lkv_cfg_if;
  logic                             valid;
  logic                             ready;
  logic signed [lkv_pkg::VAL_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/lkv_cell.sv =====
`default_nettype none

module lkv_cell (
  input  wire                                    clk_i,
  input  wire lkv_pkg::cell_ctrl_t               ctrl_i,
  input  wire                                    valid_i,
  input  wire        [lkv_pkg::KEY_W-1:0]        cmp_key_i,
  input  wire        [lkv_pkg::KEY_W-1:0]        new_key_i,
  input  wire signed [lkv_pkg::VAL_W-1:0]        new_value_i,
  input  wire        [lkv_pkg::KEY_W-1:0]        next_key_i,
  input  wire signed [lkv_pkg::VAL_W-1:0]        next_value_i,
  output logic       [lkv_pkg::KEY_W-1:0]        key_o,
  output logic signed [lkv_pkg::VAL_W-1:0]       value_o,
  output logic                                   hit_o
);

  logic        [lkv_pkg::KEY_W-1:0] key_q, key_d;
  logic signed [lkv_pkg::VAL_W-1:0] value_q, value_d;

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    priority if (ctrl_i.shift) begin
      key_d   = next_key_i;
      value_d = next_value_i;
    end else if (ctrl_i.load_new) begin
      key_d   = new_key_i;
      value_d = new_value_i;
    end else begin
      key_d   = key_q;
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign hit_o   = valid_i && (key_q == cmp_key_i);
  assign key_o   = key_q;
  assign value_o = value_q;

endmodule

`default_nettype wire

// ===== design/linear_key_value_table.sv =====
// A taken request is held in the request register and its result is registered.
// No new request is taken until the last one is done: the request register is busy
// while the cell row compares and shifts; stalled results hold the operation back.
// Reset clears the entry count, the handshake state and sets the undefined value
// to -9999; the cell contents are left as they are and are never read unwritten.
`default_nettype none

module linear_key_value_table (
  input  wire         clk_i,
  input  wire         rst_ni,
  lkv_req_if.sink     req_i,
  lkv_cfg_if.sink     cfg_i,
  lkv_rsp_if.source   rsp_o
);

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_EXEC = 1'b1;

  localparam int N = lkv_pkg::MAX_ENTRIES;

  logic                                phase_q, phase_d;
  logic        [lkv_pkg::CMD_W-1:0]    op_cmd_q;
  logic        [lkv_pkg::KEY_W-1:0]    op_key_q;
  logic signed [lkv_pkg::VAL_W-1:0]    op_value_q;
  logic        [lkv_pkg::CNT_W-1:0]    count_q, count_d;
  logic signed [lkv_pkg::VAL_W-1:0]    undef_q;

  logic                                rsp_valid_q;
  logic        [lkv_pkg::STATUS_W-1:0] rsp_status_q, status_d;
  logic signed [lkv_pkg::VAL_W-1:0]    rsp_value_q, readv_d;
  logic        [lkv_pkg::OUT_CNT_W-1:0] rsp_count_q;
  logic                                rsp_empty_q, rsp_full_q;

  logic        [lkv_pkg::KEY_W-1:0]    cell_key   [N];
  logic signed [lkv_pkg::VAL_W-1:0]    cell_value [N];
  logic        [lkv_pkg::KEY_W-1:0]    next_key   [N];
  logic signed [lkv_pkg::VAL_W-1:0]    next_value [N];
  logic        [N-1:0]                 hit, seen, cell_valid;
  lkv_pkg::cell_ctrl_t                 ctrl [N];

  logic                                req_fire, fire, present, ins_ok, del_ok;
  logic signed [lkv_pkg::VAL_W-1:0]    hit_value;

  assign req_i.ready = (phase_q == PH_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign fire        = (phase_q == PH_EXEC) && (!rsp_valid_q || rsp_o.ready);

  assign present = |hit;
  assign ins_ok  = fire && (op_cmd_q == lkv_pkg::CMD_INSERT) && !present &&
                   (count_q < lkv_pkg::CNT_W'(N));
  assign del_ok  = fire && (op_cmd_q == lkv_pkg::CMD_DELETE) && present;

  // Each cell shifts its upper neighbor down once the deleted entry lies at or below it.
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign cell_valid[i] = count_q > lkv_pkg::CNT_W'(i);
    assign seen[i]       = |hit[i:0];
    assign ctrl[i].shift    = del_ok && seen[i];
    assign ctrl[i].load_new = ins_ok && (count_q[lkv_pkg::IDX_W-1:0] == lkv_pkg::IDX_W'(i));

    if (i == N - 1) begin : g_last
      assign next_key[i]   = cell_key[i];
      assign next_value[i] = cell_value[i];
    end else begin : g_mid
      assign next_key[i]   = cell_key[i+1];
      assign next_value[i] = cell_value[i+1];
    end

    lkv_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[i]),
      .valid_i      (cell_valid[i]),
      .cmp_key_i    (op_key_q),
      .new_key_i    (op_key_q),
      .new_value_i  (op_value_q),
      .next_key_i   (next_key[i]),
      .next_value_i (next_value[i]),
      .key_o        (cell_key[i]),
      .value_o      (cell_value[i]),
      .hit_o        (hit[i])
    );
  end

  // Keys are unique, so at most one cell hits and an OR picks its value.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < N; i++) begin
      if (hit[i]) begin
        hit_value = hit_value | cell_value[i];
      end
    end
  end

  always_comb begin
    status_d = lkv_pkg::ST_OK;
    readv_d  = '0;
    count_d  = count_q;
    unique case (op_cmd_q)
      lkv_pkg::CMD_LOOKUP: begin
        if (present) begin
          readv_d = hit_value;
        end else begin
          readv_d  = undef_q;
          status_d = lkv_pkg::ST_ABSENT;
        end
      end
      lkv_pkg::CMD_INSERT: begin
        priority if (present) begin
          status_d = lkv_pkg::ST_DUP;
        end else if (count_q >= lkv_pkg::CNT_W'(N)) begin
          status_d = lkv_pkg::ST_FULL;
        end else begin
          count_d = count_q + lkv_pkg::CNT_W'(1);
        end
      end
      lkv_pkg::CMD_DELETE: begin
        if (present) begin
          count_d = count_q - lkv_pkg::CNT_W'(1);
        end else begin
          status_d = lkv_pkg::ST_ABSENT;
        end
      end
      default: begin
        status_d = lkv_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: if (req_fire) phase_d = PH_EXEC;
      PH_EXEC: if (fire) phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      undef_q     <= lkv_pkg::UNDEF_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (fire) begin
        count_q <= count_d;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        undef_q <= cfg_i.data;
      end
      if (fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_cmd_q   <= req_i.cmd;
      op_key_q   <= req_i.key;
      op_value_q <= req_i.entry_value;
    end
    if (fire) begin
      rsp_status_q <= status_d;
      rsp_value_q  <= readv_d;
      rsp_count_q  <= (lkv_pkg::OUT_CNT_W)'(count_d);
      rsp_empty_q  <= (count_d == '0);
      rsp_full_q   <= (count_d == lkv_pkg::CNT_W'(N));
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.read_value  = rsp_value_q;
  assign rsp_o.entry_count = rsp_count_q;
  assign rsp_o.is_empty    = rsp_empty_q;
  assign rsp_o.is_full     = rsp_full_q;

endmodule

`default_nettype wire

// ===== design/lkv_checker.sv =====
`default_nettype none
`include "linear_key_value_table_macros.svh"

module lkv_checker (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 req_valid_i,
  input wire                                 req_ready_i,
  input wire                                 rsp_valid_i,
  input wire                                 rsp_ready_i,
  input wire [lkv_pkg::STATUS_W-1:0]         rsp_status_i,
  input wire [lkv_pkg::VAL_W-1:0]            rsp_value_i,
  input wire [lkv_pkg::OUT_CNT_W-1:0]        rsp_count_i,
  input wire                                 rsp_empty_i,
  input wire                                 rsp_full_i
);

  localparam logic [lkv_pkg::OUT_CNT_W-1:0] FULL_CNT =
    (lkv_pkg::OUT_CNT_W)'(lkv_pkg::MAX_ENTRIES);

  `LKV_ASSERT_SAME(a_empty_flag, clk_i, rst_ni, rsp_valid_i, rsp_empty_i == (rsp_count_i == '0), "is_empty disagrees with entry_count")
  `LKV_ASSERT_SAME(a_full_flag, clk_i, rst_ni, rsp_valid_i && rsp_full_i, rsp_count_i == FULL_CNT, "is_full without a full count")
  `LKV_ASSERT_SAME(a_reject_full, clk_i, rst_ni, rsp_valid_i && rsp_status_i == lkv_pkg::ST_FULL, rsp_full_i, "insert rejected while not full")
  `LKV_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request taken while an operation is in flight")
  `LKV_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_value_i) && $stable(rsp_status_i), "stalled result changed")

endmodule

bind linear_key_value_table lkv_checker u_lkv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_value_i  (rsp_o.read_value),
  .rsp_count_i  (rsp_o.entry_count),
  .rsp_empty_i  (rsp_o.is_empty),
  .rsp_full_i   (rsp_o.is_full)
);

`default_nettype wire
